// File: design/c2d_pkg.sv
// Shared constants, types and codes for the 7x7 zero-padded convolution core.
package c2d_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int KSIZE       = 7;
	localparam int HALF_K      = KSIZE / 2;
	localparam int LINES       = KSIZE - 1;
	localparam int TAPS        = KSIZE * KSIZE;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WID_W       = 11;
	localparam int ROW_W       = 16;
	localparam int SLOT_W      = $clog2(LINES);
	localparam int PIX_W       = 8;
	localparam int COEF_W      = 16;
	localparam int IDX_W       = 6;
	localparam int PROD_W      = PIX_W + 1 + COEF_W;
	localparam int ROWSUM_W    = PROD_W + $clog2(KSIZE + 1);
	localparam int SUM_W       = 30;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_COEF  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic                     is_coef;
		logic [IDX_W-1:0]         coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic [PIX_W-1:0]         px;
		logic [COL_W-1:0]         col;
		logic [SLOT_W-1:0]        slot;
		logic                     emit;
		logic [KSIZE-1:0]         row_mask;
		logic [KSIZE-1:0]         col_mask;
		logic [ROW_W-1:0]         out_row;
		logic [COL_W-1:0]         out_col;
		logic                     last;
	} c2d_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} c2d_q_status_t;

endpackage

// File: design/conv2d_7x7_zero_pad_core.sv
// Top level of the 7x7 zero-padded convolution core.
// Input stream s_*: tuser carries the op (coefficient write, pixel, flush),
// tdata carries coef_index, coef_value and pixel. Pixels arrive in raster
// order; after a frame's last pixel, flush transfers drain the outputs that
// still lag by three rows and three pixels. Output stream m_*: tdata carries
// out_value, out_row and out_col; tlast marks the frame's last output.
// Configuration channel cfg_*: index 0 is the image width, 1 the height;
// write it only while the core is idle.
// Throughput is one input transfer per cycle while the queue has room. A
// result is offered on m_* after the queue read together with the line
// store read, then the window shift, tap multiply, row sum and final sum
// stages.
// A four-entry queue between front and back end lets the input keep
// flowing while the output waits; when a result waits and m_tready is low
// the back end pipeline holds and s_tready falls once the queue fills.
// Reset clears counters, window and kernel; the line stores are not cleared
// and need no clearing pass, since stale entries only meet masked taps.
module conv2d_7x7_zero_pad_core import c2d_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // op
	input  logic [31:0] s_tdata,   // coef_index, coef_value, pixel, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_value, out_row, out_col
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic          q_push;
	logic          q_pop;
	c2d_item_t     q_item;
	c2d_item_t     q_head;
	c2d_q_status_t q_status;

	c2d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_status (q_status),
		.push     (q_push),
		.item     (q_item)
	);

	c2d_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (q_item),
		.pop     (q_pop),
		.item_out(q_head),
		.status  (q_status)
	);

	c2d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.item_in (q_head),
		.pop     (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("front end wrote into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("back end read from an empty queue");

	a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.full && !q_pop) |=> !s_tready)
		else $error("input accepted while the queue stayed full");
`endif

endmodule

// File: design/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/c2d_front.sv
// Front end: accepts items, keeps frame counters and size registers, builds queue entries.
module c2d_front import c2d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          s_tuser,   // op
	input  logic [31:0]         s_tdata,   // coef_index, coef_value, pixel, zero fill
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  c2d_q_status_t       q_status,
	output logic                push,
	output c2d_item_t           item
);

	logic [WID_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [SLOT_W-1:0] slot_q;
	logic              frame_done_q;

	op_t               op;
	logic              acc;
	logic              active;
	logic [WID_W-1:0]  eff_w;
	logic [ROW_W-1:0]  eff_h;
	logic [27:0]       pos;
	logic [27:0]       thresh;
	logic              primed;
	logic              in_col_end;
	logic              out_col_end;
	logic              out_row_end;
	logic              last;
	logic [KSIZE-1:0]  row_mask;
	logic [KSIZE-1:0]  col_mask;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_status.full;
	assign op        = op_t'(s_tuser);
	assign acc       = s_tvalid && s_tready;
	assign active    = acc && ((op == OP_PIXEL) || ((op == OP_FLUSH) && !frame_done_q));

	always_comb begin
		if (width_q == '0) begin
			eff_w = WID_W'(1);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			eff_w = WID_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	assign pos         = 28'(in_row_q) * 28'(eff_w) + 28'(in_col_q);
	assign thresh      = 28'(HALF_K) * 28'(eff_w) + 28'(HALF_K);
	assign primed      = (out_row_q != '0) || (out_col_q != '0) || (pos >= thresh);
	assign in_col_end  = ({1'b0, in_col_q} + WID_W'(1)) >= eff_w;
	assign out_col_end = ({1'b0, out_col_q} + WID_W'(1)) >= eff_w;
	assign out_row_end = ({1'b0, out_row_q} + 17'd1) >= {1'b0, eff_h};
	assign last        = out_row_end && out_col_end;

	// A tap is live only when its row and column fall inside the image.
	always_comb begin
		logic signed [ROW_W+1:0] r;
		logic signed [COL_W+1:0] c;
		for (int i = 0; i < KSIZE; i++) begin
			r = signed'({2'b00, out_row_q}) + (ROW_W+2)'(i) - (ROW_W+2)'(HALF_K);
			c = signed'({2'b00, out_col_q}) + (COL_W+2)'(i) - (COL_W+2)'(HALF_K);
			row_mask[i] = (r >= 0) && (r < signed'({2'b00, eff_h}));
			col_mask[i] = (c >= 0) && (c < signed'({1'b0, eff_w}));
		end
	end

	always_comb begin
		item.is_coef    = (op == OP_COEF);
		item.coef_index = s_tdata[5:0];
		item.coef_value = s_tdata[21:6];
		item.px         = (op == OP_PIXEL) ? s_tdata[29:22] : '0;
		item.col        = in_col_q;
		item.slot       = slot_q;
		item.emit       = primed && (op != OP_COEF);
		item.row_mask   = row_mask;
		item.col_mask   = col_mask;
		item.out_row    = out_row_q;
		item.out_col    = out_col_q;
		item.last       = last;
		push = (acc && (op == OP_COEF) && (s_tdata[5:0] < IDX_W'(TAPS))) || active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WID_W'(1024);
			height_q     <= ROW_W'(1024);
			in_row_q     <= '0;
			in_col_q     <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			slot_q       <= '0;
			frame_done_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
					REG_HEIGHT: height_q <= cfg_data;
				endcase
			end
			if (active) begin
				frame_done_q <= primed && last;
				if (primed && last) begin
					// The frame is complete: every counter starts over.
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					slot_q    <= '0;
				end else begin
					if (in_col_end) begin
						in_col_q <= '0;
						if (in_row_q != '1) begin
							in_row_q <= in_row_q + ROW_W'(1);
						end
						slot_q <= (slot_q == SLOT_W'(LINES - 1)) ? '0 : slot_q + SLOT_W'(1);
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
					if (primed) begin
						if (out_col_end) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + ROW_W'(1);
						end else begin
							out_col_q <= out_col_q + COL_W'(1);
						end
					end
				end
			end
		end
	end

endmodule

// File: design/c2d_fifo.sv
// Short queue between the front end and the compute back end.
module c2d_fifo import c2d_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  c2d_item_t     item_in,
	input  logic          pop,
	output c2d_item_t     item_out,
	output c2d_q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	c2d_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign item_out     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: design/c2d_back.sv
// Back end: line stores, sliding window, 49 parallel taps and a registered adder tree.
module c2d_back import c2d_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  c2d_q_status_t q_status,
	input  c2d_item_t     item_in,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [55:0]   m_tdata,   // out_value, out_row, out_col
	output logic          m_tlast    // frame_end
);

	logic                       en;
	logic                       rd_en;
	logic [PIX_W-1:0]           line_rd [LINES];
	logic [PIX_W-1:0]           line_col [LINES];

	logic                       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	c2d_item_t                  item_s1, item_s2, item_s3, item_s4;
	logic [PIX_W-1:0]           window_q [KSIZE][KSIZE];
	logic signed [COEF_W-1:0]   kernel_q [TAPS];
	logic signed [PROD_W-1:0]   prod_s3 [TAPS];
	logic signed [ROWSUM_W-1:0] rowsum_s4 [KSIZE];
	logic signed [ROWSUM_W-1:0] rowsum [KSIZE];
	logic signed [SUM_W-1:0]    total;
	logic [SUM_W-1:0]           value_s5;
	logic [ROW_W-1:0]           row_s5;
	logic [COL_W-1:0]           col_s5;
	logic                       last_s5;

	// The whole pipeline advances together and freezes while a result waits.
	assign en    = !valid_s5 || m_tready;
	assign pop   = en && !q_status.empty;
	assign rd_en = pop && !item_in.is_coef;

	for (genvar g = 0; g < LINES; g++) begin : g_line
		c2d_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk  (clk),
			.we   (rd_en && (item_in.slot == SLOT_W'(g))),
			.waddr(item_in.col),
			.wdata(item_in.px),
			.re   (rd_en),
			.raddr(item_in.col),
			.rdata(line_rd[g])
		);
	end

	// Window row y takes the line written y rows after the oldest one.
	always_comb begin
		logic [SLOT_W:0] t;
		for (int y = 0; y < LINES; y++) begin
			t = {1'b0, item_s1.slot} + (SLOT_W+1)'(y);
			if (t >= (SLOT_W+1)'(LINES)) begin
				t = t - (SLOT_W+1)'(LINES);
			end
			line_col[y] = line_rd[t[SLOT_W-1:0]];
		end
	end

	always_comb begin
		for (int y = 0; y < KSIZE; y++) begin
			rowsum[y] = '0;
			for (int x = 0; x < KSIZE; x++) begin
				rowsum[y] = rowsum[y] + ROWSUM_W'(prod_s3[y*KSIZE + x]);
			end
		end
		total = '0;
		for (int y = 0; y < KSIZE; y++) begin
			total = total + SUM_W'(rowsum_s4[y]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			for (int y = 0; y < KSIZE; y++) begin
				for (int x = 0; x < KSIZE; x++) begin
					window_q[y][x] <= '0;
				end
			end
			for (int t = 0; t < TAPS; t++) begin
				kernel_q[t] <= '0;
			end
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4 && item_s4.emit;
			if (valid_s1 && item_s1.is_coef) begin
				kernel_q[item_s1.coef_index] <= item_s1.coef_value;
			end
			if (valid_s1 && !item_s1.is_coef) begin
				for (int y = 0; y < KSIZE; y++) begin
					for (int x = 0; x < KSIZE - 1; x++) begin
						window_q[y][x] <= window_q[y][x+1];
					end
				end
				for (int y = 0; y < LINES; y++) begin
					window_q[y][KSIZE-1] <= line_col[y];
				end
				window_q[KSIZE-1][KSIZE-1] <= item_s1.px;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			for (int y = 0; y < KSIZE; y++) begin
				for (int x = 0; x < KSIZE; x++) begin
					if (item_s2.row_mask[y] && item_s2.col_mask[x]) begin
						prod_s3[y*KSIZE + x] <= signed'({1'b0, window_q[y][x]})
							* kernel_q[y*KSIZE + x];
					end else begin
						prod_s3[y*KSIZE + x] <= '0;
					end
				end
			end
			for (int y = 0; y < KSIZE; y++) begin
				rowsum_s4[y] <= rowsum[y];
			end
			value_s5 <= total;
			row_s5   <= item_s4.out_row;
			col_s5   <= item_s4.out_col;
			last_s5  <= item_s4.last;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {col_s5, row_s5, value_s5};
	assign m_tlast  = last_s5;

endmodule
